>>> rtl/smon_pkg.sv
// Shared types and codes for the sample statistics percentile monitor.
package smon_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned TALLY_W  = 48;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNUSED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_USE = 8'd1;

  typedef struct packed {
    logic [TALLY_W-1:0]  over;
    logic [SAMPLE_W-1:0] max_v;
    logic [SAMPLE_W-1:0] min_v;
    logic [SUM_W-1:0]    sq;
    logic [SUM_W-1:0]    sum;
    logic [TALLY_W-1:0]  count;
  } stats_t;

endpackage

>>> rtl/sample_stats_percentile_monitor_core.sv
// Top level of the sample statistics percentile monitor.
//
// channel | direction | handshake         | contents
// s_axis  | in        | tvalid/tready     | record or query word
// m_axis  | out       | tvalid/tready     | status and statistics word
// cfg     | in        | cfg_valid/ready   | register index and data
//
// A record word passes through accept, statistics read, write back and result.
// For a query word the selection engine makes one pass over the ring of the n
// held samples per result bit, through the ring read port.
// Reset clears the statistics valid bits, the registers and all control state.
// A waiting result holds the block in its final step until m_tready.
module sample_stats_percentile_monitor_core #(
  parameter int COUNTERS = 16,
  parameter int RING_DEPTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // counter_index[3:0], sample_value[35:4], percentile_fraction[51:36]
  input  logic [55:0]  s_tdata,
  // mode[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // sample_count[47:0], sample_sum[111:48], square_sum[175:112],
  // least_sample[207:176], greatest_sample[239:208], over_count[287:240],
  // percentile_value[319:288]
  output logic [319:0] m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [smon_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);
  import smon_pkg::*;

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int NW  = $clog2(RING_DEPTH + 1);
  localparam int CIW = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
  localparam int RAW = $clog2(COUNTERS * RING_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_RANK  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]          state;
  logic [SAMPLE_W-1:0] budget_limit;
  logic [4:0]          counters_in_use;

  logic [IDX_W-1:0]    in_idx;
  logic [SAMPLE_W-1:0] in_val;
  logic [FRAC_W-1:0]   in_frac;
  logic                in_use;

  logic                mode;
  logic [CIW-1:0]      cidx;
  logic [SAMPLE_W-1:0] val;
  logic [FRAC_W-1:0]   frac;
  stats_t              cur;
  logic [PW-1:0]       cur_ptr;
  logic [SUM_W-1:0]    sq_prod;
  logic [NW-1:0]       held_n;
  logic [FRAC_W+NW-1:0] rank_prod;

  stats_t              rd_ent;
  logic [PW-1:0]       rd_ptr;
  stats_t              upd;
  logic [PW-1:0]       upd_ptr;
  logic                st_wr;

  logic [RAW-1:0]      base;
  logic [RAW-1:0]      ring_rd_addr;
  logic [SAMPLE_W-1:0] ring_rd_data;
  logic [NW-1:0]       rank_raw;
  logic [NW-1:0]       rank;
  logic                sel_start;
  logic                sel_done;
  logic [SAMPLE_W-1:0] sel_value;

  logic [1:0]          res_status;
  stats_t              res_stats;
  logic [SAMPLE_W-1:0] res_pv;

  logic [SUM_W:0]      sum_ext;
  logic [SUM_W:0]      sq_ext;

  function automatic logic [NW-1:0] held_n_in(input logic [TALLY_W-1:0] c);
    logic [NW-1:0] r;
    if (c >= TALLY_W'(RING_DEPTH)) r = NW'(RING_DEPTH);
    else r = NW'(c);
    return r;
  endfunction

  assign in_idx  = s_tdata[3:0];
  assign in_val  = s_tdata[35:4];
  assign in_frac = s_tdata[51:36];
  assign in_use  = ({1'b0, in_idx} < counters_in_use) && (32'(in_idx) < COUNTERS);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_limit    <= '0;
      counters_in_use <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BUDGET: budget_limit <= cfg_data;
        CFG_IN_USE: counters_in_use <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  smon_stats_mem #(.COUNTERS(COUNTERS), .PW(PW), .CIW(CIW)) u_stats (
    .clk(clk), .rst(rst),
    .rd_addr(CIW'(in_idx)), .rd_data(rd_ent), .rd_ptr(rd_ptr),
    .wr_en(st_wr), .wr_addr(cidx), .wr_data(upd), .wr_ptr(upd_ptr)
  );

  assign base = RAW'(cidx) * RAW'(RING_DEPTH);

  smon_ring_mem #(.RAW(RAW)) u_ring (
    .clk(clk), .wr_en(st_wr), .wr_addr(base + RAW'(cur_ptr)), .wr_data(val),
    .rd_addr(ring_rd_addr), .rd_data(ring_rd_data)
  );

  assign rank_raw  = rank_prod[FRAC_W +: NW];
  assign rank      = (rank_raw >= held_n) ? held_n - NW'(1) : rank_raw;
  assign sel_start = (state == S_RANK);

  smon_select #(.RAW(RAW), .NW(NW)) u_select (
    .clk(clk), .rst(rst), .start(sel_start), .base(base), .n(held_n), .rank(rank),
    .rd_addr(ring_rd_addr), .rd_data(ring_rd_data), .done(sel_done), .value(sel_value)
  );

  // Record update of the captured entry.
  always_comb begin
    upd     = cur;
    upd_ptr = cur_ptr;
    sum_ext = {1'b0, cur.sum} + (SUM_W + 1)'(val);
    sq_ext  = {1'b0, cur.sq} + {1'b0, sq_prod};
    if (cur.count == '0 || val < cur.min_v) upd.min_v = val;
    if (cur.count == '0 || val > cur.max_v) upd.max_v = val;
    if (cur.count != TALLY_MAX) begin
      upd.count = cur.count + TALLY_W'(1);
      upd_ptr   = (cur_ptr == PW'(RING_DEPTH - 1)) ? '0 : cur_ptr + PW'(1);
    end
    upd.sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    upd.sq  = sq_ext[SUM_W] ? {SUM_W{1'b1}} : sq_ext[SUM_W-1:0];
    if (budget_limit != '0 && val > budget_limit && cur.over != TALLY_MAX)
      upd.over = cur.over + TALLY_W'(1);
  end

  assign st_wr = (state == S_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= in_use ? S_READ : S_EMIT;
        end
        S_READ: begin
          if (mode == MODE_RECORD) state <= S_WRITE;
          else if (rd_ent.count == '0) state <= S_EMIT;
          else state <= S_RANK;
        end
        S_WRITE: state <= S_EMIT;
        S_RANK:  state <= S_WAIT;
        S_WAIT: begin
          if (sel_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mode      <= s_tuser;
        cidx      <= CIW'(in_idx);
        val       <= in_val;
        frac      <= in_frac;
        res_status <= ST_UNUSED;
        res_stats <= '0;
        res_pv    <= '0;
      end
      S_READ: begin
        cur     <= rd_ent;
        cur_ptr <= rd_ptr;
        sq_prod <= val * val;
        if (rd_ent.count >= TALLY_W'(RING_DEPTH)) held_n <= NW'(RING_DEPTH);
        else held_n <= NW'(rd_ent.count);
        if (mode == MODE_QUERY && rd_ent.count == '0) res_status <= ST_EMPTY;
      end
      S_WRITE: begin
        res_status <= ST_OK;
        res_stats  <= upd;
      end
      S_RANK: begin
        rank_prod <= '0;
      end
      S_WAIT: begin
        if (sel_done) begin
          res_status <= ST_OK;
          res_stats  <= cur;
          res_pv     <= sel_value;
        end
      end
      default: ;
    endcase
    if (state == S_READ) rank_prod <= frac * held_n_in(rd_ent.count);
    if (state == S_EMIT && (!m_tvalid || m_tready)) begin
      m_tuser <= res_status;
      m_tdata <= {res_pv, res_stats.over, res_stats.max_v, res_stats.min_v,
                  res_stats.sq, res_stats.sum, res_stats.count};
    end
  end

endmodule

>>> rtl/smon_stats_mem.sv
// Per-counter statistics table with write pointers and valid bits.
module smon_stats_mem #(
  parameter int COUNTERS = 16,
  parameter int PW = 10,
  parameter int CIW = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CIW-1:0]         rd_addr,
  output smon_pkg::stats_t       rd_data,
  output logic [PW-1:0]          rd_ptr,
  input  logic                   wr_en,
  input  logic [CIW-1:0]         wr_addr,
  input  smon_pkg::stats_t       wr_data,
  input  logic [PW-1:0]          wr_ptr
);
  import smon_pkg::*;

  stats_t        mem [COUNTERS];
  logic [PW-1:0] ptr_mem [COUNTERS];
  logic [COUNTERS-1:0] valid;
  stats_t        rd_q;
  logic [PW-1:0] ptr_q;
  logic          vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      ptr_mem[wr_addr] <= wr_ptr;
    end
    rd_q <= mem[rd_addr];
    ptr_q <= ptr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) valid[wr_addr] <= 1'b1;
      vld_q <= valid[rd_addr];
    end
  end

  // An entry never written reads as the all-zero reset value.
  assign rd_data = vld_q ? rd_q : '0;
  assign rd_ptr  = vld_q ? ptr_q : '0;

endmodule

>>> rtl/smon_ring_mem.sv
// Sample ring storage for all counters, one write and one read port.
module smon_ring_mem #(
  parameter int RAW = 14
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [RAW-1:0]                wr_addr,
  input  logic [smon_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [RAW-1:0]                rd_addr,
  output logic [smon_pkg::SAMPLE_W-1:0] rd_data
);
  import smon_pkg::*;

  logic [SAMPLE_W-1:0] mem [2**RAW];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/smon_select.sv
// Radix selection engine: finds the sample of a given rank, one bit per ring pass.
module smon_select #(
  parameter int RAW = 14,
  parameter int NW = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [RAW-1:0]                base,
  input  logic [NW-1:0]                 n,
  input  logic [NW-1:0]                 rank,
  output logic [RAW-1:0]                rd_addr,
  input  logic [smon_pkg::SAMPLE_W-1:0] rd_data,
  output logic                          done,
  output logic [smon_pkg::SAMPLE_W-1:0] value
);
  import smon_pkg::*;

  localparam logic [1:0] E_IDLE   = 2'd0;
  localparam logic [1:0] E_SCAN   = 2'd1;
  localparam logic [1:0] E_DRAIN  = 2'd2;
  localparam logic [1:0] E_DECIDE = 2'd3;

  logic [1:0]          state;
  logic [NW-1:0]       pos;
  logic [NW-1:0]       cnt;
  logic [NW-1:0]       k;
  logic [4:0]          bit_n;
  logic [SAMPLE_W-1:0] prefix;
  logic                rd_pend;
  logic [SAMPLE_W-1:0] hi_mask;
  logic                match;

  assign rd_addr = base + RAW'(pos);
  assign value   = prefix;

  // A sample counts when it agrees with the prefix above the current bit and
  // has a zero in that bit.
  assign hi_mask = ({SAMPLE_W{1'b1}} << bit_n) << 1;
  assign match   = (((rd_data ^ prefix) & hi_mask) == '0) && !rd_data[bit_n];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= E_IDLE;
      done    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= (state == E_SCAN);
      unique case (state)
        E_IDLE: begin
          if (start) state <= E_SCAN;
        end
        E_SCAN: begin
          if (pos == n - NW'(1)) state <= E_DRAIN;
        end
        E_DRAIN: state <= E_DECIDE;
        E_DECIDE: begin
          if (bit_n == 5'd0) begin
            state <= E_IDLE;
            done  <= 1'b1;
          end else begin
            state <= E_SCAN;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        prefix <= '0;
        k      <= rank;
        bit_n  <= 5'd31;
        cnt    <= '0;
        pos    <= '0;
      end
      E_SCAN: begin
        pos <= pos + NW'(1);
        if (rd_pend && match) cnt <= cnt + NW'(1);
      end
      E_DRAIN: begin
        if (rd_pend && match) cnt <= cnt + NW'(1);
      end
      default: begin
        if (k >= cnt) begin
          prefix[bit_n] <= 1'b1;
          k <= k - cnt;
        end
        cnt <= '0;
        pos <= '0;
        if (bit_n != 5'd0) bit_n <= bit_n - 5'd1;
      end
    endcase
  end

endmodule
